### design/dsq_pkg.sv
package dsq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int TIME_BITS   = 32;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_TICK    = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DEC,
        ST_POP,
        ST_EMIT
    } t_state;

    // contents of one cell as seen by its neighbors
    typedef struct packed {
        logic                 occ;
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] delta;
    } t_link;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                 tok_start;
        logic                 tok_step;
        logic                 place_en;
        logic                 dec;
        logic                 pop;
        logic [ID_BITS-1:0]   ins_id;
        logic [TIME_BITS-1:0] ins_rem;
    } t_cell_cmd;

    // summary of the chain for the controller
    typedef struct packed {
        logic                 full;
        logic                 head_occ;
        logic                 head_zero;
        logic [ID_BITS-1:0]   head_id;
        logic                 next_zero;
        logic                 tok_occ;
        logic [TIME_BITS-1:0] tok_delta;
    } t_q_view;

endpackage

### design/dsq_cell.sv
module dsq_cell import dsq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  logic      i_head,
    input  logic      i_tok,
    input  logic      i_shift,
    input  t_link     i_left,
    input  t_link     i_right,
    output t_link     o_link,
    output logic      o_tok,
    output logic      o_shift
);

    logic                 r_occ, n_occ;
    logic                 r_tok, n_tok;
    logic [ID_BITS-1:0]   r_id, n_id;
    logic [TIME_BITS-1:0] r_delta, n_delta;
    logic                 w_place;

    assign w_place = r_tok & i_cmd.place_en;

    always_comb begin
        n_occ   = r_occ;
        n_id    = r_id;
        n_delta = r_delta;
        if (i_cmd.pop) begin
            n_occ   = i_right.occ;
            n_id    = i_right.id;
            n_delta = i_right.delta;
        end else if (w_place) begin
            n_occ   = 1'b1;
            n_id    = i_cmd.ins_id;
            n_delta = i_cmd.ins_rem;
        end else if (i_shift) begin
            n_occ   = i_left.occ;
            n_id    = i_left.id;
            // the displaced entry keeps only what lies beyond the new one
            n_delta = (i_tok & i_cmd.place_en) ? (i_left.delta - i_cmd.ins_rem)
                                               : i_left.delta;
        end else if (i_cmd.dec && i_head && (r_delta != '0)) begin
            n_delta = r_delta - TIME_BITS'(1);
        end
    end

    // the token walks one cell a cycle until the insert finds its slot
    always_comb begin
        n_tok = r_tok;
        if (i_cmd.tok_step) begin
            n_tok = i_cmd.place_en ? 1'b0 : i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_tok <= 1'b0;
        end else begin
            r_occ <= n_occ;
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_delta <= n_delta;
    end

    assign o_link.occ   = r_occ;
    assign o_link.id    = r_id;
    assign o_link.delta = r_delta;
    assign o_tok        = r_tok;
    assign o_shift      = i_shift | w_place;

endmodule

### design/dsq_ctrl.sv
module dsq_ctrl import dsq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic [ID_BITS-1:0]   i_thread_id,
    input  logic [TIME_BITS-1:0] i_sleep_time,
    input  t_q_view              i_view,
    output t_cell_cmd            o_cmd,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ID_BITS-1:0]   o_woken_id,
    output logic                 o_woke_valid,
    output logic                 o_status,
    output logic                 o_last
);

    t_state               r_state, n_state;
    logic [ID_BITS-1:0]   r_id;
    logic [TIME_BITS-1:0] r_rem;
    logic                 r_status;
    logic                 w_accept, w_out_free, w_hit, w_pop_now;
    logic                 w_emit, w_e_wv, w_e_status, w_e_last;
    logic [ID_BITS-1:0]   w_e_id;

    assign w_accept   = i_valid & o_ready;
    assign w_out_free = !o_valid | i_ready;
    assign w_hit      = !i_view.tok_occ | (r_rem < i_view.tok_delta);
    assign w_pop_now  = i_view.head_occ & i_view.head_zero;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_req_type == REQ_TICK) begin
                        n_state = ST_DEC;
                    end else if (i_view.full) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_DEC: n_state = ST_POP;
            ST_POP: begin
                if (w_out_free) begin
                    n_state = (w_pop_now && i_view.next_zero) ? ST_POP : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = (r_state == ST_IDLE);
        o_cmd.tok_start  = (r_state == ST_IDLE) & i_valid & (i_req_type == REQ_INSERT)
                           & !i_view.full;
        o_cmd.tok_step   = o_cmd.tok_start | (r_state == ST_SCAN);
        o_cmd.place_en   = (r_state == ST_SCAN) & w_hit;
        o_cmd.dec        = (r_state == ST_DEC);
        o_cmd.pop        = (r_state == ST_POP) & w_out_free & w_pop_now;
        o_cmd.ins_id     = r_id;
        o_cmd.ins_rem    = r_rem;
        w_emit           = 1'b0;
        w_e_id           = '0;
        w_e_wv           = 1'b0;
        w_e_status       = STATUS_OK;
        w_e_last         = 1'b1;
        case (r_state)
            ST_POP: begin
                w_emit = w_out_free;
                if (w_pop_now) begin
                    w_e_id   = i_view.head_id;
                    w_e_wv   = 1'b1;
                    w_e_last = !i_view.next_zero;
                end
            end
            ST_EMIT: begin
                w_emit     = w_out_free;
                w_e_status = r_status;
            end
            default: w_emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id     <= i_thread_id;
            // zero sleep wakes on the next tick
            r_rem    <= (i_sleep_time == '0) ? TIME_BITS'(1) : i_sleep_time;
            r_status <= i_view.full ? STATUS_FULL : STATUS_OK;
        end else if ((r_state == ST_SCAN) && !w_hit) begin
            r_rem <= r_rem - i_view.tok_delta;
        end
        if (w_emit) begin
            o_woken_id   <= w_e_id;
            o_woke_valid <= w_e_wv;
            o_status     <= w_e_status;
            o_last       <= w_e_last;
        end
    end

endmodule

### design/delta_sleep_queue.sv
// delta_sleep_queue: a thread sleep queue kept as a delta list in a row of cells
//
// input channel (i_valid / o_ready): i_req_type selects an insert of
// i_thread_id for i_sleep_time ticks, or one timer tick. o_ready is high
// only while the block is idle; one item is worked on at a time.
// output channel (o_valid / i_ready): an insert gives one result with
// o_status set when the queue was full. a tick gives one result per woken
// thread, o_last on the final one, or one result with o_woke_valid low.
// an insert walks a token down the cells, one cell a cycle, until it finds
// its slot; an insert into a full queue skips the walk.
// a tick decrements the head, then pops each woken thread in turn.
// the token walk over the cell chain sets the insert time.
// results sit in an output register; a stalled receiver holds the block in
// the result state until the transfer, the queue contents stay unchanged.
// reset (i_rst_n low, synchronous) empties the queue and drops any result.
module delta_sleep_queue import dsq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic [ID_BITS-1:0]   i_thread_id,
    input  logic [TIME_BITS-1:0] i_sleep_time,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ID_BITS-1:0]   o_woken_id,
    output logic                 o_woke_valid,
    output logic                 o_status,
    output logic                 o_last
);

    t_cell_cmd w_cmd;
    t_q_view   w_view;
    t_link     w_link  [QUEUE_DEPTH];
    t_link     w_left  [QUEUE_DEPTH];
    t_link     w_right [QUEUE_DEPTH];
    logic      w_tok_in  [QUEUE_DEPTH];
    logic      w_shift_in[QUEUE_DEPTH];
    logic      w_tok     [QUEUE_DEPTH];
    logic      w_shift   [QUEUE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_left[g]     = '0;
                assign w_tok_in[g]   = w_cmd.tok_start;
                assign w_shift_in[g] = 1'b0;
            end else begin : g_rest
                assign w_left[g]     = w_link[g-1];
                assign w_tok_in[g]   = w_tok[g-1];
                assign w_shift_in[g] = w_shift[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_end
                assign w_right[g] = '0;
            end else begin : g_mid
                assign w_right[g] = w_link[g+1];
            end

            dsq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_head  ((g == 0) ? 1'b1 : 1'b0),
                .i_tok   (w_tok_in[g]),
                .i_shift (w_shift_in[g]),
                .i_left  (w_left[g]),
                .i_right (w_right[g]),
                .o_link  (w_link[g]),
                .o_tok   (w_tok[g]),
                .o_shift (w_shift[g])
            );
        end
    endgenerate

    // summarize the chain for the controller and select the cell that holds the token
    always_comb begin
        w_view.full      = w_link[QUEUE_DEPTH-1].occ;
        w_view.head_occ  = w_link[0].occ;
        w_view.head_zero = (w_link[0].delta == '0);
        w_view.head_id   = w_link[0].id;
        w_view.next_zero = w_link[1].occ & (w_link[1].delta == '0);
        w_view.tok_occ   = 1'b0;
        w_view.tok_delta = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_view.tok_occ   = w_view.tok_occ | (w_tok[k] & w_link[k].occ);
            w_view.tok_delta = w_view.tok_delta | (w_tok[k] ? w_link[k].delta : '0);
        end
    end

    dsq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_thread_id  (i_thread_id),
        .i_sleep_time (i_sleep_time),
        .i_view       (w_view),
        .o_cmd        (w_cmd),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_woken_id   (o_woken_id),
        .o_woke_valid (o_woke_valid),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule
